@@ rtl/i2cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the I2C bit-bang master: command codes,
// register indexes, reset values and the records passed between modules.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    localparam int HALF_W    = 8;
    localparam int TIMEOUT_W = 9;
    localparam int CFG_W     = 9;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 9'd250;

    // register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // kind codes on the input stream
    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_STOP     = 3'd1;
    localparam logic [2:0] KIND_WRITE    = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_WAIT_ACK = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_WAIT_ACK
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic       ack_after_read;
        logic       sda_level;
    } tick_item_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    typedef struct packed {
        logic             wr_en;
        logic             index;
        logic [CFG_W-1:0] wdata;
    } cfg_write_t;

endpackage

@@ rtl/i2cbb_front.sv @@
// ----------------------------------------------------------------------------
// i2cbb_front
// Accepts tick items, decodes the command kind and queues the items
// for the bit engine.
// ----------------------------------------------------------------------------
module i2cbb_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd_valid,
    input  logic [2:0]             kind,
    input  logic [7:0]             data_byte,
    input  logic                   ack_after_read,
    input  logic                   sda_level,
    output logic                   item_valid,
    output i2cbb_pkg::tick_item_t  item,
    input  logic                   item_pop
);

    i2cbb_pkg::tick_item_t mem [i2cbb_pkg::FIFO_DEPTH];

    logic [i2cbb_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [i2cbb_pkg::PTR_W-1:0] wr_ptr_next;
    logic [i2cbb_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [i2cbb_pkg::PTR_W-1:0] rd_ptr_next;
    logic [i2cbb_pkg::CNT_W-1:0] count_reg;
    logic [i2cbb_pkg::CNT_W-1:0] count_next;

    i2cbb_pkg::tick_item_t in_item;
    i2cbb_pkg::cmd_t       cmd_dec;
    logic                  push;
    logic                  pop;

    always_comb
    begin
        cmd_dec = i2cbb_pkg::CMD_NONE;
        if (cmd_valid)
        begin
            unique case (kind)
                i2cbb_pkg::KIND_START:    cmd_dec = i2cbb_pkg::CMD_START;
                i2cbb_pkg::KIND_STOP:     cmd_dec = i2cbb_pkg::CMD_STOP;
                i2cbb_pkg::KIND_WRITE:    cmd_dec = i2cbb_pkg::CMD_WRITE;
                i2cbb_pkg::KIND_READ:     cmd_dec = i2cbb_pkg::CMD_READ;
                i2cbb_pkg::KIND_WAIT_ACK: cmd_dec = i2cbb_pkg::CMD_WAIT_ACK;
                default:                  cmd_dec = i2cbb_pkg::CMD_NONE;
            endcase
        end
    end

    assign in_item.cmd            = cmd_dec;
    assign in_item.data_byte      = data_byte;
    assign in_item.ack_after_read = ack_after_read;
    assign in_item.sda_level      = sda_level;

    assign in_ready   = (count_reg != i2cbb_pkg::CNT_W'(i2cbb_pkg::FIFO_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/i2cbb_engine.sv @@
// ----------------------------------------------------------------------------
// i2cbb_engine
// Bit engine: plays each command out as timed SCL/SDA segments, one queued
// tick per cycle unless a result waits in its output register for the consumer.
// ----------------------------------------------------------------------------
module i2cbb_engine
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2cbb_pkg::cfg_write_t  cfg,
    input  logic                   item_valid,
    input  i2cbb_pkg::tick_item_t  item,
    output logic                   item_pop,
    output logic                   res_valid,
    output i2cbb_pkg::result_t     res,
    input  logic                   res_ready
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WRITE,
        PH_READ,
        PH_RACK,
        PH_WPRE,
        PH_POLL,
        PH_WPOST
    } phase_t;

    logic [i2cbb_pkg::HALF_W-1:0]    half_reg;
    logic [i2cbb_pkg::TIMEOUT_W-1:0] timeout_reg;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [3:0]                      bit_index_reg;
    logic [3:0]                      bit_index_next;
    logic [7:0]                      shifter_reg;
    logic [7:0]                      shifter_next;
    logic [7:0]                      tick_count_reg;
    logic [7:0]                      tick_count_next;
    logic [i2cbb_pkg::TIMEOUT_W-1:0] wait_count_reg;
    logic [i2cbb_pkg::TIMEOUT_W-1:0] wait_count_next;
    logic                            scl_reg;
    logic                            scl_next;
    logic                            sda_reg;
    logic                            sda_next;
    logic                            ack_flag_reg;
    logic                            ack_flag_next;
    logic [7:0]                      rx_byte_reg;
    logic [7:0]                      rx_byte_next;
    logic                            ack_send_reg;
    logic                            ack_send_next;
    logic                            done_next;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    i2cbb_pkg::result_t              res_reg;
    i2cbb_pkg::result_t              res_next;

    logic [7:0]                      reload_val;
    logic                            pop;

    // drive levels {scl, sda} after entering segment s of a phase
    function automatic logic [1:0] apply_seg(phase_t ph, logic [3:0] s, logic bit7,
                                             logic ack_s, logic [1:0] lines);
        logic [1:0] r;
        r = lines;
        unique case (ph)
            PH_START:
            begin
                if (s == 4'd0)      r = 2'b11;
                else if (s == 4'd1) r[0] = 1'b0;
                else                r[1] = 1'b0;
            end
            PH_STOP:
            begin
                if (s == 4'd0)      r[0] = 1'b0;
                else if (s == 4'd1) r[1] = 1'b1;
                else                r[0] = 1'b1;
            end
            PH_WRITE:
            begin
                if (!s[0])
                begin
                    if (s != 4'd0) r[1] = 1'b0;
                    r[0] = bit7;
                end
                else
                begin
                    r[1] = 1'b1;
                end
            end
            PH_READ:
            begin
                r[1] = !s[0];
            end
            PH_RACK:
            begin
                if (s == 4'd0)      r[0] = !ack_s;
                else if (s == 4'd1) r[1] = 1'b1;
                else if (s == 4'd2) r[1] = 1'b0;
                else                r[0] = 1'b1;
            end
            PH_WPRE:
            begin
                if (s == 4'd0) r[0] = 1'b1;
                else           r[1] = 1'b1;
            end
            PH_WPOST:
            begin
                r[1] = 1'b0;
            end
            default:
            begin
                r = lines;
            end
        endcase
        return r;
    endfunction

    function automatic logic [4:0] seg_total(phase_t ph, logic ack_s);
        logic [4:0] n;
        unique case (ph)
            PH_START: n = 5'd3;
            PH_STOP:  n = 5'd3;
            PH_WRITE: n = 5'd16;
            PH_READ:  n = 5'd16;
            PH_RACK:  n = ack_s ? 5'd4 : 5'd3;
            PH_WPRE:  n = 5'd2;
            default:  n = 5'd1;
        endcase
        return n;
    endfunction

    assign reload_val = (half_reg == '0) ? 8'd1 : half_reg;
    assign pop        = item_valid && (!res_valid_reg || res_ready);
    assign item_pop   = pop;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        phase_t                          ph_b;
        logic [1:0]                      lines;
        logic [3:0]                      s;
        logic [7:0]                      sh;
        logic [7:0]                      tick_dec;
        logic                            poll_now;
        logic [i2cbb_pkg::TIMEOUT_W-1:0] poll_count;

        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shifter_next    = shifter_reg;
        tick_count_next = tick_count_reg;
        wait_count_next = wait_count_reg;
        ack_flag_next   = ack_flag_reg;
        rx_byte_next    = rx_byte_reg;
        ack_send_next   = ack_send_reg;
        done_next       = 1'b0;
        lines           = {scl_reg, sda_reg};
        ph_b            = PH_IDLE;
        s               = bit_index_reg;
        sh              = shifter_reg;
        tick_dec        = tick_count_reg;
        poll_now        = 1'b0;
        poll_count      = wait_count_reg;

        if (pop)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item.cmd != i2cbb_pkg::CMD_NONE)
                    begin
                        unique case (item.cmd)
                            i2cbb_pkg::CMD_START: ph_b = PH_START;
                            i2cbb_pkg::CMD_STOP:  ph_b = PH_STOP;
                            i2cbb_pkg::CMD_WRITE:
                            begin
                                ph_b         = PH_WRITE;
                                shifter_next = item.data_byte;
                            end
                            i2cbb_pkg::CMD_READ:
                            begin
                                ph_b          = PH_READ;
                                shifter_next  = 8'd0;
                                ack_send_next = item.ack_after_read;
                            end
                            default: ph_b = PH_WPRE;
                        endcase
                        phase_next      = ph_b;
                        bit_index_next  = 4'd0;
                        lines           = apply_seg(ph_b, 4'd0, shifter_next[7],
                                                    ack_send_next, lines);
                        tick_count_next = reload_val;
                    end
                end
                PH_POLL:
                begin
                    poll_now   = 1'b1;
                    poll_count = wait_count_reg;
                end
                default:
                begin
                    tick_dec        = (tick_count_reg != 8'd0) ? tick_count_reg - 8'd1
                                                               : tick_count_reg;
                    tick_count_next = tick_dec;
                    if (tick_dec == 8'd0)
                    begin
                        if (phase_reg == PH_READ && !s[0])
                        begin
                            sh = {shifter_reg[6:0], item.sda_level};
                        end
                        if (phase_reg == PH_WRITE && s[0])
                        begin
                            sh = {shifter_reg[6:0], 1'b0};
                        end
                        shifter_next = sh;
                        if ({1'b0, s} + 5'd1 < seg_total(phase_reg, ack_send_reg))
                        begin
                            bit_index_next  = s + 4'd1;
                            lines           = apply_seg(phase_reg, s + 4'd1, sh[7],
                                                        ack_send_reg, lines);
                            tick_count_next = reload_val;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_READ:
                                begin
                                    rx_byte_next    = sh;
                                    phase_next      = PH_RACK;
                                    bit_index_next  = 4'd0;
                                    lines           = apply_seg(PH_RACK, 4'd0, sh[7],
                                                                ack_send_reg, lines);
                                    tick_count_next = reload_val;
                                end
                                PH_WPRE:
                                begin
                                    phase_next = PH_POLL;
                                    poll_now   = 1'b1;
                                    poll_count = '0;
                                end
                                PH_WRITE:
                                begin
                                    lines      = 2'b01;
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                PH_WPOST:
                                begin
                                    ack_flag_next = 1'b0;
                                    phase_next    = PH_IDLE;
                                    done_next     = 1'b1;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            endcase

            if (poll_now)
            begin
                wait_count_next = poll_count;
                if (!item.sda_level)
                begin
                    phase_next      = PH_WPOST;
                    bit_index_next  = 4'd0;
                    lines[1]        = 1'b0;
                    tick_count_next = reload_val;
                end
                else if (poll_count >= timeout_reg)
                begin
                    ack_flag_next = 1'b1;
                    phase_next    = PH_IDLE;
                    done_next     = 1'b1;
                end
                else
                begin
                    wait_count_next = poll_count + 1'b1;
                end
            end
        end

        scl_next = lines[1];
        sda_next = lines[0];
    end

    always_comb
    begin
        res_valid_next     = res_valid_reg;
        res_next           = res_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (pop)
        begin
            res_valid_next     = 1'b1;
            res_next.scl_out    = scl_next;
            res_next.sda_out    = sda_next;
            res_next.busy_res   = (phase_next != PH_IDLE);
            res_next.done_res   = done_next;
            res_next.read_data  = rx_byte_next;
            res_next.ack_failed = ack_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg       <= i2cbb_pkg::HALF_RESET;
            timeout_reg    <= i2cbb_pkg::TIMEOUT_RESET;
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            shifter_reg    <= '0;
            tick_count_reg <= '0;
            wait_count_reg <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_flag_reg   <= 1'b0;
            rx_byte_reg    <= '0;
            ack_send_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.wr_en)
            begin
                unique case (cfg.index)
                    i2cbb_pkg::CFG_HALF_PERIOD:
                        half_reg <= cfg.wdata[i2cbb_pkg::HALF_W-1:0];
                    default:
                        timeout_reg <= cfg.wdata[i2cbb_pkg::TIMEOUT_W-1:0];
                endcase
            end
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shifter_reg    <= shifter_next;
            tick_count_reg <= tick_count_next;
            wait_count_reg <= wait_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_flag_reg   <= ack_flag_next;
            rx_byte_reg    <= rx_byte_next;
            ack_send_reg   <= ack_send_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ rtl/i2c_bit_bang_master_core.sv @@
// latency: a result is presented on the clock edge after its tick is taken
// (queue read and engine update are combinational, loaded into the output register)
// throughput: one tick item per cycle while m_axis_tready keeps the output register free
// reset: engine idle, SCL and SDA released high, half period 2, ack timeout 250
// ----------------------------------------------------------------------------
// i2c_bit_bang_master_core
// I2C master bit engine: a front queue of tick items feeding the timed
// SCL/SDA sequencer, one result per tick.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [i2cbb_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // data_byte, ack_after_read, sda_level
    input  logic [3:0]                   s_axis_tuser,  // cmd_valid, kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata   // scl_out, sda_out, busy_res,
                                                        // done_res, read_data, ack_failed
);

    i2cbb_pkg::cfg_write_t cfg;
    i2cbb_pkg::tick_item_t item;
    i2cbb_pkg::result_t    res;
    logic                  item_valid;
    logic                  item_pop;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    i2cbb_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .cmd_valid      (s_axis_tuser[0]),
        .kind           (s_axis_tuser[3:1]),
        .data_byte      (s_axis_tdata[7:0]),
        .ack_after_read (s_axis_tdata[8]),
        .sda_level      (s_axis_tdata[9]),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    i2cbb_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, res.ack_failed, res.read_data, res.done_res,
                           res.busy_res, res.sda_out, res.scl_out};

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C bit-bang master core. Tick items carry
// start, stop, write, read and wait-ack commands together with a sampled SDA
// level. An in-bench model of the SCL/SDA sequencer predicts one bus result
// per tick, and every output transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT = 4000;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_START,
        ENG_STOP,
        ENG_WRITE,
        ENG_READ,
        ENG_RACK,
        ENG_WPRE,
        ENG_POLL,
        ENG_WPOST
    } eng_phase_t;

    typedef enum int {
        SDA_RANDOM,
        SDA_LOW,
        SDA_HIGH,
        SDA_ACK_SOON
    } sda_mode_t;

    typedef struct {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        logic       ack_rd;
        logic       sda;
    } tick_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_index = 1'b0;
    logic [i2cbb_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata = '0;   // data_byte, ack_after_read, sda_level
    logic [3:0]                    s_axis_tuser = '0;   // cmd_valid, kind
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;        // scl_out, sda_out, busy_res,
                                                        // done_res, read_data, ack_failed

    i2c_bit_bang_master_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // bus engine model state
    logic [i2cbb_pkg::HALF_W-1:0]    cfg_half = i2cbb_pkg::HALF_RESET;
    logic [i2cbb_pkg::TIMEOUT_W-1:0] cfg_timeout = i2cbb_pkg::TIMEOUT_RESET;
    eng_phase_t                      eng_phase = ENG_IDLE;
    logic [3:0]                      seg_idx = '0;
    logic [7:0]                      shift_reg = '0;
    logic [7:0]                      tick_left = '0;
    logic [8:0]                      poll_count = '0;
    logic                            scl_q = 1'b1;
    logic                            sda_q = 1'b1;
    logic                            ack_fail_q = 1'b0;
    logic [7:0]                      rx_byte_q = '0;
    logic                            send_ack = 1'b0;
    logic                            done_q = 1'b0;

    i2cbb_pkg::result_t expected_bus_q[$];
    int      err_count = 0;
    int      ticks_sent = 0;
    int      tx_gap_pct = 0;
    int      rx_stall_pct = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    function automatic int seg_count(eng_phase_t ph);
        case (ph)
            ENG_START: return 3;
            ENG_STOP:  return 3;
            ENG_WRITE: return 16;
            ENG_READ:  return 16;
            ENG_RACK:  return send_ack ? 4 : 3;
            ENG_WPRE:  return 2;
            default:   return 1;
        endcase
    endfunction

    task automatic drive_segment();
        case (eng_phase)
            ENG_START:
            begin
                if (seg_idx == 0)
                begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end
                else if (seg_idx == 1)
                    sda_q = 1'b0;
                else
                    scl_q = 1'b0;
            end
            ENG_STOP:
            begin
                if (seg_idx == 0)
                    sda_q = 1'b0;
                else if (seg_idx == 1)
                    scl_q = 1'b1;
                else
                    sda_q = 1'b1;
            end
            ENG_WRITE:
            begin
                if (!seg_idx[0])
                begin
                    if (seg_idx != 0)
                        scl_q = 1'b0;
                    sda_q = shift_reg[7];
                end
                else
                    scl_q = 1'b1;
            end
            ENG_READ:
                scl_q = !seg_idx[0];
            ENG_RACK:
            begin
                if (seg_idx == 0)
                    sda_q = !send_ack;
                else if (seg_idx == 1)
                    scl_q = 1'b1;
                else if (seg_idx == 2)
                    scl_q = 1'b0;
                else
                    sda_q = 1'b1;
            end
            ENG_WPRE:
            begin
                if (seg_idx == 0)
                    sda_q = 1'b1;
                else
                    scl_q = 1'b1;
            end
            ENG_WPOST:
                scl_q = 1'b0;
            default:
            begin
            end
        endcase
    endtask

    task automatic reload_ticks();
        tick_left = (cfg_half == 0) ? 8'd1 : cfg_half;
    endtask

    task automatic enter_phase(eng_phase_t ph);
        eng_phase = ph;
        seg_idx = '0;
        drive_segment();
        reload_ticks();
    endtask

    task automatic finish_command();
        eng_phase = ENG_IDLE;
        done_q = 1'b1;
    endtask

    task automatic poll_sda(logic sda);
        if (!sda)
            enter_phase(ENG_WPOST);
        else if (poll_count >= cfg_timeout)
        begin
            ack_fail_q = 1'b1;
            finish_command();
        end
        else
            poll_count = poll_count + 1'b1;
    endtask

    task automatic end_segment(logic sda);
        int s;
        s = seg_idx;
        if (eng_phase == ENG_READ && (s % 2) == 0)
            shift_reg = {shift_reg[6:0], sda};
        if (eng_phase == ENG_WRITE && (s % 2) == 1)
            shift_reg = {shift_reg[6:0], 1'b0};
        if (s + 1 < seg_count(eng_phase))
        begin
            seg_idx = 4'(s + 1);
            drive_segment();
            reload_ticks();
        end
        else
        begin
            case (eng_phase)
                ENG_READ:
                begin
                    rx_byte_q = shift_reg;
                    enter_phase(ENG_RACK);
                end
                ENG_WPRE:
                begin
                    eng_phase = ENG_POLL;
                    poll_count = '0;
                    poll_sda(sda);
                end
                ENG_WRITE:
                begin
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                    finish_command();
                end
                ENG_WPOST:
                begin
                    ack_fail_q = 1'b0;
                    finish_command();
                end
                default:
                    finish_command();
            endcase
        end
    endtask

    task automatic step_bus_engine(tick_t t, output i2cbb_pkg::result_t r);
        done_q = 1'b0;
        if (eng_phase == ENG_IDLE)
        begin
            if (t.valid && t.kind <= i2cbb_pkg::KIND_WAIT_ACK)
            begin
                case (t.kind)
                    i2cbb_pkg::KIND_START: enter_phase(ENG_START);
                    i2cbb_pkg::KIND_STOP:  enter_phase(ENG_STOP);
                    i2cbb_pkg::KIND_WRITE:
                    begin
                        shift_reg = t.data;
                        enter_phase(ENG_WRITE);
                    end
                    i2cbb_pkg::KIND_READ:
                    begin
                        shift_reg = '0;
                        send_ack = t.ack_rd;
                        enter_phase(ENG_READ);
                    end
                    default: enter_phase(ENG_WPRE);
                endcase
            end
        end
        else if (eng_phase == ENG_POLL)
            poll_sda(t.sda);
        else
        begin
            if (tick_left > 0)
                tick_left = tick_left - 1'b1;
            if (tick_left == 0)
                end_segment(t.sda);
        end
        r.scl_out    = scl_q;
        r.sda_out    = sda_q;
        r.busy_res   = (eng_phase != ENG_IDLE);
        r.done_res   = done_q;
        r.read_data  = rx_byte_q;
        r.ack_failed = ack_fail_q;
    endtask

    function automatic logic pick_sda(sda_mode_t mode);
        case (mode)
            SDA_LOW:      return 1'b0;
            SDA_HIGH:     return 1'b1;
            SDA_ACK_SOON: return ($urandom_range(99) < 30);
            default:      return 1'($urandom_range(1));
        endcase
    endfunction

    function automatic tick_t noise_tick(sda_mode_t mode);
        tick_t t;
        t.valid  = 1'($urandom_range(1));
        t.kind   = 3'($urandom_range(7));
        t.data   = 8'($urandom_range(255));
        t.ack_rd = 1'($urandom_range(1));
        t.sda    = pick_sda(mode);
        return t;
    endfunction

    function automatic tick_t make_cmd(logic [2:0] kind, logic [7:0] data, logic ack_rd);
        tick_t t;
        t.valid  = 1'b1;
        t.kind   = kind;
        t.data   = data;
        t.ack_rd = ack_rd;
        t.sda    = 1'($urandom_range(1));
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        i2cbb_pkg::result_t r;
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, t.sda, t.ack_rd, t.data};
        s_axis_tuser  <= {t.kind, t.valid};
        do
            @(posedge clk);
        while (!s_axis_tready);
        step_bus_engine(t, r);
        expected_bus_q.push_back(r);
        ticks_sent++;
    endtask

    // keep ticking until the engine goes idle
    task automatic run_out(sda_mode_t mode);
        while (eng_phase != ENG_IDLE)
            send_tick(noise_tick(mode));
    endtask

    task automatic issue(tick_t cmd, sda_mode_t mode);
        send_tick(cmd);
        run_out(mode);
    endtask

    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [i2cbb_pkg::CFG_W-1:0] val);
        settle_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == i2cbb_pkg::CFG_HALF_PERIOD)
            cfg_half = val[i2cbb_pkg::HALF_W-1:0];
        else
            cfg_timeout = val[i2cbb_pkg::TIMEOUT_W-1:0];
    endtask

    task automatic random_transaction();
        int n_bytes;
        if ($urandom_range(99) < 15)
        begin
            issue(noise_tick(SDA_RANDOM), SDA_RANDOM);
            return;
        end
        issue(make_cmd(i2cbb_pkg::KIND_START, '0, 1'b0), SDA_RANDOM);
        n_bytes = $urandom_range(1, 3);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(99) < 60)
            begin
                issue(make_cmd(i2cbb_pkg::KIND_WRITE, 8'($urandom_range(255)), 1'b0),
                      SDA_RANDOM);
                issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0),
                      ($urandom_range(99) < 80) ? SDA_ACK_SOON : SDA_HIGH);
            end
            else
                issue(make_cmd(i2cbb_pkg::KIND_READ, '0, (i != n_bytes - 1)), SDA_RANDOM);
        end
        if ($urandom_range(99) < 10)
            issue(noise_tick(SDA_RANDOM), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_STOP, '0, 1'b0), SDA_RANDOM);
    endtask

    task automatic test_commands();
        issue(make_cmd(i2cbb_pkg::KIND_START, '0, 1'b0), SDA_RANDOM);
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd1);
        write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'd3);
        issue(make_cmd(i2cbb_pkg::KIND_START, '0, 1'b0), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_WRITE, 8'h00, 1'b0), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_WRITE, 8'hFF, 1'b1), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_WRITE, 8'hA5, 1'b0), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0), SDA_LOW);
        issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0), SDA_HIGH);
        issue(make_cmd(i2cbb_pkg::KIND_READ, '0, 1'b1), SDA_HIGH);
        issue(make_cmd(i2cbb_pkg::KIND_READ, '0, 1'b0), SDA_LOW);
        issue(make_cmd(i2cbb_pkg::KIND_READ, '0, 1'b1), SDA_RANDOM);
        issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0), SDA_ACK_SOON);
        for (int k = i2cbb_pkg::KIND_WAIT_ACK + 1; k < 8; k++)
            issue(make_cmd(3'(k), 8'($urandom_range(255)), 1'b1), SDA_RANDOM);
        begin
            tick_t t;
            t = make_cmd(i2cbb_pkg::KIND_START, '0, 1'b0);
            t.valid = 1'b0;
            issue(t, SDA_RANDOM);
        end
        issue(make_cmd(i2cbb_pkg::KIND_STOP, '0, 1'b0), SDA_RANDOM);
    endtask

    task automatic test_register_extremes();
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd0);
        issue(make_cmd(i2cbb_pkg::KIND_START, '0, 1'b0), SDA_RANDOM);
        write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'd0);
        issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0), SDA_HIGH);
        write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'd511);
        issue(make_cmd(i2cbb_pkg::KIND_WAIT_ACK, '0, 1'b0), SDA_HIGH);
        // longest half period on the first segment only
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd255);
        send_tick(make_cmd(i2cbb_pkg::KIND_STOP, '0, 1'b0));
        repeat (3) send_tick(noise_tick(SDA_RANDOM));
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd1);
        run_out(SDA_RANDOM);
        // period change while a byte is on the wire
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd3);
        send_tick(make_cmd(i2cbb_pkg::KIND_WRITE, 8'($urandom_range(255)), 1'b0));
        repeat (5) send_tick(noise_tick(SDA_RANDOM));
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd1);
        run_out(SDA_RANDOM);
        write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'd1);
    endtask

    task automatic test_backpressure();
        int start_ticks;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'd2);
        hold_left = 300;
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < 40)
            random_transaction();
    endtask

    task automatic test_random_traffic(int n_ticks, int tx_pct, int rx_pct);
        int start_ticks;
        tx_gap_pct = tx_pct;
        rx_stall_pct = rx_pct;
        write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'($urandom_range(1, 3)));
        write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'($urandom_range(0, 12)));
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < n_ticks)
        begin
            if ($urandom_range(99) < 8)
            begin
                if ($urandom_range(1))
                    write_reg(i2cbb_pkg::CFG_HALF_PERIOD, 9'($urandom_range(0, 3)));
                else
                    write_reg(i2cbb_pkg::CFG_ACK_TIMEOUT, 9'($urandom_range(0, 12)));
            end
            random_transaction();
        end
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        i2cbb_pkg::result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = i2cbb_pkg::result_t'(m_axis_tdata[$bits(i2cbb_pkg::result_t)-1:0]);
            if (expected_bus_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected transfer, expected none, actual %0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_bus_q.pop_front();
                check_field("scl_out", want.scl_out, got.scl_out);
                check_field("sda_out", want.sda_out, got.sda_out);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_failed", want.ack_failed, got.ack_failed);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(25, 0, 0);
        test_random_traffic(25, 59, 0);
        test_random_traffic(25, 0, 59);
        test_random_traffic(25, 38, 38);
        settle_pipeline();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
